// ===== rtl/i2cmbe_pkg.sv =====
`timescale 1ns / 1ps

package i2cmbe_pkg;

  // Sequencer states, one per line phase
  typedef enum logic [3:0] {
    ST_IDLE = 4'd0,
    ST_SA1  = 4'd1,
    ST_SA2  = 4'd2,
    ST_SP1  = 4'd3,
    ST_SP2  = 4'd4,
    ST_SP3  = 4'd5,
    ST_WL   = 4'd6,
    ST_WH   = 4'd7,
    ST_RL   = 4'd8,
    ST_RH   = 4'd9,
    ST_KL   = 4'd10,
    ST_KH   = 4'd11,
    ST_AR   = 4'd12,
    ST_AH   = 4'd13,
    ST_AP   = 4'd14
  } state_e;

  // Command codes
  localparam logic [2:0] REQ_START = 3'd0;
  localparam logic [2:0] REQ_STOP  = 3'd1;
  localparam logic [2:0] REQ_WRITE = 3'd2;
  localparam logic [2:0] REQ_READ  = 3'd3;
  localparam logic [2:0] REQ_WAIT  = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd1;

  localparam logic [7:0] PHASE_TICKS_RST = 8'd2;
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_fail;
  } result_t;

endpackage

// ===== rtl/i2c_master_byte_engine.sv =====
`timescale 1ns / 1ps
// The result of an item is in the output register the cycle after it is taken.
// One item per cycle while s_axis_tready is high; sequencer and line levels step once per taken item.
// s_axis_tready stays high while the output register is empty or being drained.
// Reset (asynchronous, active low): sequencer idle, SCL and SDA high and driven, counters and
// received byte zero, phase_ticks 2, ack_timeout 250, no result pending.
module i2c_master_byte_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [15:0]                         s_axis_tdata,  // tx_byte, send_ack, sda_in
  input  logic [3:0]                          s_axis_tuser,  // cmd_valid, req_type
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // scl_out, sda_out, sda_drive, busy_res, done_res, rx_byte, ack_fail
  output logic [15:0]                         m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [i2cmbe_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [7:0]                          cfg_wdata_i
);
  import i2cmbe_pkg::*;

  logic       accept;
  item_t      item;
  result_t    res;
  logic       m_valid_q;
  logic [15:0] m_data_q;
  logic [7:0] phase_ticks_q;
  logic [7:0] ack_timeout_q;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign item.cmd_valid = s_axis_tuser[0];
  assign item.req_type  = s_axis_tuser[3:1];
  assign item.tx_byte   = s_axis_tdata[7:0];
  assign item.send_ack  = s_axis_tdata[8];
  assign item.sda_in    = s_axis_tdata[9];

  i2cmbe_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (accept),
    .item_i        (item),
    .phase_ticks_i (phase_ticks_q),
    .ack_timeout_i (ack_timeout_q),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PHASE_TICKS_RST;
      ack_timeout_q <= ACK_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PHASE_TICKS: phase_ticks_q <= cfg_wdata_i;
        CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (accept) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_data_q <= {2'b00, res.ack_fail, res.rx_byte, res.done_res, res.busy_res,
                   res.sda_drive, res.sda_out, res.scl_out};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== rtl/i2cmbe_seq.sv =====
`timescale 1ns / 1ps

module i2cmbe_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  i2cmbe_pkg::item_t  item_i,
  input  logic [7:0]         phase_ticks_i,
  input  logic [7:0]         ack_timeout_i,
  output i2cmbe_pkg::result_t res_o
);
  import i2cmbe_pkg::*;

  state_e     state_q, state_d;
  logic [7:0] shift_q, shift_d;
  logic [3:0] bit_cnt_q, bit_cnt_d;
  logic [7:0] phase_q, phase_d;
  logic [7:0] poll_q, poll_d;
  logic [7:0] rx_q, rx_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       drv_q, drv_d;
  logic       ack_latch_q, ack_latch_d;
  logic       fail_mark_q, fail_mark_d;

  logic       expired;
  logic [3:0] bit_cnt_nx;
  logic       last_bit;
  logic [7:0] phase_ld;
  logic       phase_load;
  logic       done;
  logic       fail;
  logic       poll_hit;

  assign expired    = (phase_q == 8'd0);
  assign bit_cnt_nx = bit_cnt_q + 4'd1;
  assign last_bit   = bit_cnt_nx[3];
  assign phase_ld   = (phase_ticks_i == 8'd0) ? 8'd0 : phase_ticks_i - 8'd1;
  assign poll_hit   = (poll_q == ack_timeout_i);

  // Next state
  always_comb begin
    state_d = state_q;
    if (en_i) begin
      case (state_q)
        ST_IDLE: begin
          if (item_i.cmd_valid) begin
            case (item_i.req_type)
              REQ_START: state_d = ST_SA1;
              REQ_STOP:  state_d = ST_SP1;
              REQ_WRITE: state_d = ST_WL;
              REQ_READ:  state_d = ST_RL;
              REQ_WAIT:  state_d = ST_AR;
              default:   state_d = ST_IDLE;
            endcase
          end
        end
        ST_AP: begin
          if (!item_i.sda_in) begin
            state_d = ST_IDLE;
          end else if (poll_hit) begin
            state_d = ST_SP1;
          end
        end
        default: begin
          if (expired) begin
            case (state_q)
              ST_SA1:  state_d = ST_SA2;
              ST_SA2:  state_d = ST_IDLE;
              ST_SP1:  state_d = ST_SP2;
              ST_SP2:  state_d = ST_SP3;
              ST_SP3:  state_d = ST_IDLE;
              ST_WL:   state_d = ST_WH;
              ST_WH:   state_d = last_bit ? ST_IDLE : ST_WL;
              ST_RL:   state_d = ST_RH;
              ST_RH:   state_d = last_bit ? ST_KL : ST_RL;
              ST_KL:   state_d = ST_KH;
              ST_KH:   state_d = ST_IDLE;
              ST_AR:   state_d = ST_AH;
              ST_AH:   state_d = ST_AP;
              default: state_d = ST_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  // Datapath and line levels
  always_comb begin
    shift_d     = shift_q;
    bit_cnt_d   = bit_cnt_q;
    poll_d      = poll_q;
    rx_d        = rx_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    drv_d       = drv_q;
    ack_latch_d = ack_latch_q;
    fail_mark_d = fail_mark_q;
    if (en_i) begin
      case (state_q)
        ST_IDLE: begin
          if (item_i.cmd_valid) begin
            case (item_i.req_type)
              REQ_START: begin
                scl_d = 1'b1;
                sda_d = 1'b1;
                drv_d = 1'b1;
              end
              REQ_STOP: begin
                fail_mark_d = 1'b0;
                scl_d       = 1'b0;
                sda_d       = 1'b0;
                drv_d       = 1'b1;
              end
              REQ_WRITE: begin
                shift_d   = item_i.tx_byte;
                bit_cnt_d = 4'd0;
                scl_d     = 1'b0;
                sda_d     = item_i.tx_byte[7];
                drv_d     = 1'b1;
              end
              REQ_READ: begin
                shift_d     = 8'd0;
                bit_cnt_d   = 4'd0;
                ack_latch_d = item_i.send_ack;
                scl_d       = 1'b0;
                sda_d       = 1'b1;
                drv_d       = 1'b0;
              end
              REQ_WAIT: begin
                sda_d = 1'b1;
                drv_d = 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_AP: begin
          if (!item_i.sda_in) begin
            scl_d = 1'b0;
          end else if (poll_hit) begin
            // timed out: run a stop and flag it at the end
            fail_mark_d = 1'b1;
            scl_d       = 1'b0;
            sda_d       = 1'b0;
            drv_d       = 1'b1;
          end else begin
            poll_d = poll_q + 8'd1;
          end
        end
        default: begin
          if (expired) begin
            case (state_q)
              ST_SA1: sda_d = 1'b0;
              ST_SA2: scl_d = 1'b0;
              ST_SP1: scl_d = 1'b1;
              ST_SP2: sda_d = 1'b1;
              ST_SP3: fail_mark_d = 1'b0;
              ST_WL:  scl_d = 1'b1;
              ST_WH: begin
                shift_d   = {shift_q[6:0], 1'b0};
                bit_cnt_d = bit_cnt_nx;
                scl_d     = 1'b0;
                if (!last_bit) begin
                  sda_d = shift_q[6];
                end
              end
              ST_RL:  scl_d = 1'b1;
              ST_RH: begin
                shift_d   = {shift_q[6:0], item_i.sda_in};
                bit_cnt_d = bit_cnt_nx;
                scl_d     = 1'b0;
                if (last_bit) begin
                  rx_d  = {shift_q[6:0], item_i.sda_in};
                  sda_d = !ack_latch_q;
                  drv_d = 1'b1;
                end
              end
              ST_KL:  scl_d = 1'b1;
              ST_KH:  scl_d = 1'b0;
              ST_AR:  scl_d = 1'b1;
              ST_AH:  poll_d = 8'd0;
              default: begin
              end
            endcase
          end
        end
      endcase
    end
  end

  // Reload the phase counter on every entry to a timed phase
  assign phase_load = en_i && (state_d != state_q) && (state_d != ST_IDLE)
                      && (state_d != ST_AP);

  always_comb begin
    phase_d = phase_q;
    if (phase_load) begin
      phase_d = phase_ld;
    end else if (en_i && (state_q != ST_IDLE) && (state_q != ST_AP) && !expired) begin
      phase_d = phase_q - 8'd1;
    end
  end

  assign done = en_i && (state_q != ST_IDLE) && (state_d == ST_IDLE);
  assign fail = done && (state_q == ST_SP3) && fail_mark_q;

  assign res_o.scl_out   = scl_d;
  assign res_o.sda_out   = drv_d ? sda_d : 1'b1;
  assign res_o.sda_drive = drv_d;
  assign res_o.busy_res  = (state_d != ST_IDLE);
  assign res_o.done_res  = done;
  assign res_o.rx_byte   = rx_d;
  assign res_o.ack_fail  = fail;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      shift_q     <= 8'd0;
      bit_cnt_q   <= 4'd0;
      phase_q     <= 8'd0;
      poll_q      <= 8'd0;
      rx_q        <= 8'd0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      drv_q       <= 1'b1;
      ack_latch_q <= 1'b0;
      fail_mark_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      shift_q     <= shift_d;
      bit_cnt_q   <= bit_cnt_d;
      phase_q     <= phase_d;
      poll_q      <= poll_d;
      rx_q        <= rx_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      drv_q       <= drv_d;
      ack_latch_q <= ack_latch_d;
      fail_mark_q <= fail_mark_d;
    end
  end

  a_fail_from_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fail |-> (state_q == ST_SP3) && fail_mark_q)
    else $error("ack failure flagged outside a failing stop");

  a_low_poll_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && (state_q == ST_AP) && !item_i.sda_in |=> state_q == ST_IDLE)
    else $error("low acknowledge poll did not end the wait");

  a_bit_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_cnt_q <= 4'd8)
    else $error("bit counter past eight");

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(state_q) && $stable(phase_q) && $stable(scl_q))
    else $error("sequencer moved without an item");

endmodule
